@@ sv/pls_pkg.sv @@
// ----------------------------------------------------------------------------
// pls_pkg
// Shared widths, field layout, codes and command/status types for the
// fixed-point particle update block.
// ----------------------------------------------------------------------------
`default_nettype none

package pls_pkg;

  localparam int WORD_W        = 32;
  localparam int RADIUS_W      = 31;
  localparam int LIFE_W        = 16;
  localparam int ALPHA_W       = 8;
  localparam int MODE_W        = 3;
  localparam int PICK_W        = 2;
  localparam int CFG_IDX_W     = 3;
  localparam int FRAC_BITS_DEF = 16;

  // divider dividend: 32-bit magnitude times 16-bit life
  localparam int DIVD_W = WORD_W + LIFE_W;

  // input tdata layout, lowest bit first
  localparam int IN_RAD_LSB   = 6 * WORD_W;
  localparam int IN_LIFE_LSB  = IN_RAD_LSB + RADIUS_W;
  localparam int IN_ALPHA_LSB = IN_LIFE_LSB + LIFE_W;
  localparam int IN_MODE_LSB  = IN_ALPHA_LSB + ALPHA_W;
  localparam int IN_PICK_LSB  = IN_MODE_LSB + MODE_W;
  localparam int IN_USED_W    = IN_PICK_LSB + PICK_W;
  localparam int IN_DATA_W    = ((IN_USED_W + 7) / 8) * 8;

  // output tdata layout
  localparam int OUT_USED_W = 3 * WORD_W + RADIUS_W + ALPHA_W + LIFE_W + 1;
  localparam int OUT_DATA_W = ((OUT_USED_W + 7) / 8) * 8;

  // request kinds
  localparam logic REQ_SPAWN = 1'b0;
  localparam logic REQ_TICK  = 1'b1;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_GROW    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_GRAVITY = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_GRAV_ON = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_CHASE   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_DEST_X  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_DEST_Y  = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_DEST_Z  = 3'd6;

  // size modes
  localparam logic [MODE_W-1:0] MODE_NONE   = 3'd0;
  localparam logic [MODE_W-1:0] MODE_GROW   = 3'd1;
  localparam logic [MODE_W-1:0] MODE_SHRINK = 3'd2;
  localparam logic [MODE_W-1:0] MODE_LIFE   = 3'd3;
  localparam logic [MODE_W-1:0] MODE_DAMP   = 3'd4;

  // shrink picks
  localparam logic [PICK_W-1:0] PICK_97 = 2'd0;
  localparam logic [PICK_W-1:0] PICK_98 = 2'd1;
  localparam logic [PICK_W-1:0] PICK_99 = 2'd2;

  // division jobs; the three axis jobs are numbered as the axes
  localparam int JOB_W = 3;
  localparam logic [JOB_W-1:0] JOB_X     = 3'd0;
  localparam logic [JOB_W-1:0] JOB_Y     = 3'd1;
  localparam logic [JOB_W-1:0] JOB_Z     = 3'd2;
  localparam logic [JOB_W-1:0] JOB_RAD   = 3'd3;
  localparam logic [JOB_W-1:0] JOB_ALPHA = 3'd4;

  typedef struct packed {
    logic              capture;
    logic              spawn;
    logic              grav;
    logic              move;
    logic              prep;
    logic              div_start;
    logic              store;
    logic              size;
    logic              life;
    logic              out_load;
    logic [JOB_W-1:0]  job;
  } pls_cmd_t;

  typedef struct packed {
    logic              chase;
    logic [MODE_W-1:0] mode;
    logic              alive;
    logic              life_one;
    logic              div_done;
  } pls_stat_t;

  // round(h / 100 * 2^f)
  function automatic longint fix_const(input longint h, input int f);
    fix_const = ((h << f) + 50) / 100;
  endfunction

endpackage

`default_nettype wire

@@ sv/pls_div.sv @@
// ----------------------------------------------------------------------------
// pls_div
// Restoring unsigned divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module pls_div
  import pls_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              start,
  input  wire logic [DIVD_W-1:0] dividend,
  input  wire logic [LIFE_W-1:0] divisor,
  output logic                   done,
  output logic [DIVD_W-1:0]      quotient
);

  localparam int CNT_W = $clog2(DIVD_W + 1);

  logic              busy;
  logic [CNT_W-1:0]  cnt;
  logic [LIFE_W-1:0] rem;
  logic [DIVD_W-1:0] quo;
  logic [LIFE_W:0]   trial;
  logic              fits;

  // shift in the next dividend bit and try the subtract
  assign trial    = {rem, quo[DIVD_W-1]};
  assign fits     = trial >= {1'b0, divisor};
  assign quotient = quo;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= CNT_W'(DIVD_W);
      end else if (busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == CNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (start) begin
      quo <= dividend;
      rem <= '0;
    end else if (busy) begin
      quo <= {quo[DIVD_W-2:0], fits};
      rem <= fits ? LIFE_W'(trial - {1'b0, divisor}) : trial[LIFE_W-1:0];
    end
  end

endmodule

`default_nettype wire

@@ sv/pls_dp.sv @@
// ----------------------------------------------------------------------------
// pls_dp
// Particle state, configuration registers, shared multiplier and divider,
// and the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module pls_dp
  import pls_pkg::*;
#(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire pls_cmd_t              cmd,
  output pls_stat_t                  st,
  input  wire logic [IN_DATA_W-1:0]  in_data,
  input  wire logic                  cfg_we,
  input  wire logic [CFG_IDX_W-1:0]  cfg_idx,
  input  wire logic [WORD_W-1:0]     cfg_val,
  output logic [OUT_DATA_W-1:0]      out_data
);

  localparam int KW = FRAC_BITS + 1;
  localparam logic [KW-1:0] K_97   = KW'(fix_const(97, FRAC_BITS));
  localparam logic [KW-1:0] K_98   = KW'(fix_const(98, FRAC_BITS));
  localparam logic [KW-1:0] K_99   = KW'(fix_const(99, FRAC_BITS));
  localparam logic [KW-1:0] K_DAMP = KW'(fix_const(15, FRAC_BITS));
  localparam logic [RADIUS_W-1:0] RAD_MAX = '1;

  // configuration
  logic [WORD_W-1:0] grow_step, gravity_step;
  logic              gravity_on, chase_on;
  logic [WORD_W-1:0] dest_pos [3];

  // particle state
  logic [WORD_W-1:0]   origin_pos [3];
  logic [WORD_W-1:0]   offset_pos [3];
  logic [WORD_W-1:0]   velocity   [3];
  logic [WORD_W-1:0]   shown_pos  [3];
  logic [RADIUS_W-1:0] cur_radius, full_radius;
  logic [LIFE_W-1:0]   life_count, full_life;
  logic [ALPHA_W-1:0]  base_alpha, alpha_r;
  logic [MODE_W-1:0]   mode_reg;
  logic                alive_flag;
  logic [PICK_W-1:0]   pick;

  // multiplier / divider operands
  logic [DIVD_W-1:0] prod;
  logic              neg_r;
  logic              div_done;
  logic [DIVD_W-1:0] quo;

  assign st.chase    = chase_on;
  assign st.mode     = mode_reg;
  assign st.alive    = alive_flag;
  assign st.life_one = life_count == LIFE_W'(1);
  assign st.div_done = div_done;

  // input field unpack
  logic [RADIUS_W-1:0] in_rad;
  logic [LIFE_W-1:0]   in_life;
  assign in_rad  = in_data[IN_RAD_LSB +: RADIUS_W];
  assign in_life = in_data[IN_LIFE_LSB +: LIFE_W];

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      grow_step    <= '0;
      gravity_step <= '0;
      gravity_on   <= 1'b0;
      chase_on     <= 1'b0;
      dest_pos[0]  <= '0;
      dest_pos[1]  <= '0;
      dest_pos[2]  <= '0;
    end else if (cfg_we) begin
      case (cfg_idx)
        CFG_GROW:    grow_step    <= cfg_val;
        CFG_GRAVITY: gravity_step <= cfg_val;
        CFG_GRAV_ON: gravity_on   <= cfg_val[0];
        CFG_CHASE:   chase_on     <= cfg_val[0];
        CFG_DEST_X:  dest_pos[0]  <= cfg_val;
        CFG_DEST_Y:  dest_pos[1]  <= cfg_val;
        CFG_DEST_Z:  dest_pos[2]  <= cfg_val;
        default: ;
      endcase
    end
  end

  // chase difference for the axis of the current job
  logic [1:0]          ax;
  logic [WORD_W:0]     diff;
  logic [WORD_W-1:0]   mag;
  logic [WORD_W-1:0]   mul_a;
  logic [LIFE_W-1:0]   mul_b;
  logic                is_axis;

  assign ax      = cmd.job[1:0];
  assign is_axis = cmd.job == JOB_X || cmd.job == JOB_Y || cmd.job == JOB_Z;

  always_comb begin
    diff = '0;
    if (is_axis) begin
      diff = {dest_pos[ax][WORD_W-1], dest_pos[ax]}
           - {origin_pos[ax][WORD_W-1], origin_pos[ax]};
    end
    mag = diff[WORD_W] ? WORD_W'(-diff) : diff[WORD_W-1:0];
  end

  always_comb begin
    case (cmd.job)
      JOB_X, JOB_Y, JOB_Z: begin
        mul_a = mag;
        mul_b = full_life - life_count;
      end
      JOB_RAD: begin
        mul_a = WORD_W'(full_radius);
        mul_b = life_count;
      end
      JOB_ALPHA: begin
        mul_a = WORD_W'(base_alpha);
        mul_b = life_count;
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  // shared multiplier, registered before the divider
  always_ff @(posedge clk) begin
    if (cmd.prep) begin
      prod  <= mul_a * mul_b;
      neg_r <= is_axis && diff[WORD_W];
    end
  end

  pls_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (cmd.div_start),
    .dividend (prod),
    .divisor  (full_life),
    .done     (div_done),
    .quotient (quo)
  );

  // signed quotient for chase
  logic [WORD_W-1:0] q32;
  assign q32 = neg_r ? WORD_W'(-quo[WORD_W-1:0]) : quo[WORD_W-1:0];

  // radius grow with saturation
  logic signed [WORD_W+1:0] grow_sum;
  logic [RADIUS_W-1:0]      grow_rad;
  assign grow_sum = $signed({3'b000, cur_radius})
                  + $signed({{2{grow_step[WORD_W-1]}}, grow_step});
  always_comb begin
    if (grow_sum < 0)
      grow_rad = '0;
    else if (grow_sum > $signed({3'b000, RAD_MAX}))
      grow_rad = RAD_MAX;
    else
      grow_rad = grow_sum[RADIUS_W-1:0];
  end

  // random shrink
  logic [KW-1:0]          k_pick;
  logic [RADIUS_W+KW-1:0] shrink_prod;
  always_comb begin
    case (pick)
      PICK_97: k_pick = K_97;
      PICK_98: k_pick = K_98;
      PICK_99: k_pick = K_99;
      default: k_pick = '0;
    endcase
  end
  assign shrink_prod = cur_radius * k_pick;

  // velocity damping, one multiplier per axis
  logic signed [WORD_W+KW:0] damp_prod [3];
  logic [WORD_W-1:0]         damp_vel  [3];
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      damp_prod[i] = $signed(velocity[i]) * $signed({1'b0, K_DAMP});
      damp_vel[i]  = velocity[i] - WORD_W'(damp_prod[i] >>> FRAC_BITS);
    end
  end

  // particle state update
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < 3; i++) begin
        origin_pos[i] <= '0;
        offset_pos[i] <= '0;
        velocity[i]   <= '0;
        shown_pos[i]  <= '0;
      end
      cur_radius  <= '0;
      full_radius <= '0;
      life_count  <= '0;
      full_life   <= LIFE_W'(1);
      base_alpha  <= '0;
      alpha_r     <= '0;
      mode_reg    <= MODE_NONE;
      alive_flag  <= 1'b0;
      pick        <= PICK_97;
    end else begin
      if (cmd.capture)
        pick <= in_data[IN_PICK_LSB +: PICK_W];

      if (cmd.spawn) begin
        for (int i = 0; i < 3; i++) begin
          origin_pos[i] <= in_data[i*WORD_W +: WORD_W];
          shown_pos[i]  <= in_data[i*WORD_W +: WORD_W];
          velocity[i]   <= in_data[(i+3)*WORD_W +: WORD_W];
          offset_pos[i] <= '0;
        end
        cur_radius  <= in_rad;
        full_radius <= in_rad;
        life_count  <= (in_life == '0) ? LIFE_W'(1) : in_life;
        full_life   <= (in_life == '0) ? LIFE_W'(1) : in_life;
        base_alpha  <= in_data[IN_ALPHA_LSB +: ALPHA_W];
        alpha_r     <= in_data[IN_ALPHA_LSB +: ALPHA_W];
        mode_reg    <= in_data[IN_MODE_LSB +: MODE_W];
        alive_flag  <= 1'b1;
      end

      if (cmd.grav && gravity_on)
        velocity[1] <= velocity[1] - gravity_step;

      // plain move: accumulate velocity
      if (cmd.move && !chase_on) begin
        for (int i = 0; i < 3; i++) begin
          offset_pos[i] <= offset_pos[i] + velocity[i];
          shown_pos[i]  <= origin_pos[i] + offset_pos[i] + velocity[i];
        end
      end

      if (cmd.store) begin
        case (cmd.job)
          JOB_X, JOB_Y, JOB_Z: shown_pos[ax] <= origin_pos[ax] + q32;
          JOB_RAD:             cur_radius    <= quo[RADIUS_W-1:0];
          JOB_ALPHA:           alpha_r       <= quo[ALPHA_W-1:0];
          default: ;
        endcase
      end

      if (cmd.size) begin
        case (mode_reg)
          MODE_GROW: cur_radius <= grow_rad;
          MODE_SHRINK: begin
            if (pick == PICK_97 || pick == PICK_98 || pick == PICK_99)
              cur_radius <= RADIUS_W'(shrink_prod >> FRAC_BITS);
          end
          MODE_DAMP: begin
            for (int i = 0; i < 3; i++)
              velocity[i] <= damp_vel[i];
          end
          default: ;
        endcase
      end

      // count down; expiry clears the fade
      if (cmd.life) begin
        life_count <= life_count - 1'b1;
        if (life_count == LIFE_W'(1)) begin
          alive_flag <= 1'b0;
          alpha_r    <= '0;
        end
      end
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_data <= OUT_DATA_W'({
        ~alive_flag,
        alive_flag ? life_count : {LIFE_W{1'b0}},
        alive_flag ? alpha_r : {ALPHA_W{1'b0}},
        cur_radius,
        shown_pos[2], shown_pos[1], shown_pos[0]
      });
    end
  end

endmodule

`default_nettype wire

@@ sv/pls_ctrl.sv @@
// ----------------------------------------------------------------------------
// pls_ctrl
// Sequencer for spawn and tick items: steps the datapath through gravity,
// move, divider jobs, size update and life countdown, and owns the handshakes.
// ----------------------------------------------------------------------------
`default_nettype none

module pls_ctrl
  import pls_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst,
  input  wire logic      s_tvalid,
  output logic           s_tready,
  input  wire logic      s_tuser,
  output logic           m_tvalid,
  input  wire logic      m_tready,
  output pls_cmd_t       cmd,
  input  wire pls_stat_t st
);

  typedef enum logic [9:0] {
    S_IDLE  = 10'b00_0000_0001,
    S_GRAV  = 10'b00_0000_0010,
    S_MOVE  = 10'b00_0000_0100,
    S_PREP  = 10'b00_0000_1000,
    S_DIV   = 10'b00_0001_0000,
    S_WAIT  = 10'b00_0010_0000,
    S_STORE = 10'b00_0100_0000,
    S_SIZE  = 10'b00_1000_0000,
    S_LIFE  = 10'b01_0000_0000,
    S_OUT   = 10'b10_0000_0000
  } state_t;

  state_t           state, state_next;
  logic [JOB_W-1:0] job, job_next;
  logic             m_tvalid_next;
  logic             life_mode;

  assign s_tready  = state == S_IDLE;
  assign life_mode = st.mode == MODE_LIFE || st.mode == MODE_DAMP;

  always_comb begin
    state_next    = state;
    job_next      = job;
    cmd           = '0;
    cmd.job       = job;
    m_tvalid_next = m_tvalid && !m_tready;
    case (state)
      S_IDLE: begin
        if (s_tvalid) begin
          cmd.capture = 1'b1;
          if (s_tuser == REQ_SPAWN) begin
            cmd.spawn  = 1'b1;
            state_next = S_OUT;
          end else if (st.alive) begin
            state_next = S_GRAV;
          end else begin
            state_next = S_OUT;
          end
        end
      end
      S_GRAV: begin
        cmd.grav   = 1'b1;
        state_next = S_MOVE;
      end
      S_MOVE: begin
        cmd.move = 1'b1;
        if (st.chase) begin
          job_next   = JOB_X;
          state_next = S_PREP;
        end else if (life_mode) begin
          job_next   = JOB_RAD;
          state_next = S_PREP;
        end else begin
          state_next = S_SIZE;
        end
      end
      S_PREP: begin
        cmd.prep   = 1'b1;
        state_next = S_DIV;
      end
      S_DIV: begin
        cmd.div_start = 1'b1;
        state_next    = S_WAIT;
      end
      S_WAIT: begin
        if (st.div_done)
          state_next = S_STORE;
      end
      S_STORE: begin
        cmd.store = 1'b1;
        case (job)
          JOB_X: begin
            job_next   = JOB_Y;
            state_next = S_PREP;
          end
          JOB_Y: begin
            job_next   = JOB_Z;
            state_next = S_PREP;
          end
          JOB_Z: begin
            if (life_mode) begin
              job_next   = JOB_RAD;
              state_next = S_PREP;
            end else begin
              state_next = S_SIZE;
            end
          end
          JOB_RAD: state_next = S_SIZE;
          default: state_next = S_OUT;
        endcase
      end
      S_SIZE: begin
        cmd.size   = 1'b1;
        state_next = S_LIFE;
      end
      S_LIFE: begin
        cmd.life = 1'b1;
        if (st.life_one) begin
          state_next = S_OUT;
        end else begin
          job_next   = JOB_ALPHA;
          state_next = S_PREP;
        end
      end
      S_OUT: begin
        if (!m_tvalid || m_tready) begin
          cmd.out_load  = 1'b1;
          m_tvalid_next = 1'b1;
          state_next    = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      job      <= JOB_X;
      m_tvalid <= 1'b0;
    end else begin
      state    <= state_next;
      job      <= job_next;
      m_tvalid <= m_tvalid_next;
    end
  end

  // a result never overwrites one that is still waiting
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    cmd.out_load |-> (!m_tvalid || m_tready))
    else $error("output register overwritten while pending");

  // divider start is always followed by the wait state
  a_div_wait: assert property (@(posedge clk) disable iff (rst)
    (state == S_DIV) |=> (state == S_WAIT))
    else $error("divider started without waiting");

  // a quotient is stored only after the divider reported done
  a_store_done: assert property (@(posedge clk) disable iff (rst)
    (state == S_STORE) |-> $past(st.div_done))
    else $error("quotient stored before divider finished");

  // a free output slot is filled on leaving the output state
  a_out_fill: assert property (@(posedge clk) disable iff (rst)
    (state == S_OUT && !m_tvalid) |=> m_tvalid)
    else $error("result not presented");

endmodule

`default_nettype wire

@@ sv/particle_life_step.sv @@
// A spawn item goes from acceptance to the output state, which waits for a
// free result slot. A tick runs gravity, move, size and life for a live one,
// with J (0 to 5) divisions as needed. The block takes one item at a time.
// Each division steps through prep, start, 48 quotient bits and done, store.
// Reset (rst, synchronous): no live particle, all state zero, full life 1.
// ----------------------------------------------------------------------------
// particle_life_step
// Single-particle fixed-point update: spawn loads a particle, each tick on a
// live one moves it, applies its size mode, counts life down and fades alpha.
// ----------------------------------------------------------------------------
`default_nettype none

module particle_life_step
  import pls_pkg::*;
#(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  // input items
  input  wire logic                  s_tvalid,
  output logic                       s_tready,
  // start_x, start_y, start_z, vel_x, vel_y, vel_z, start_radius,
  // start_life, start_alpha, size_mode, random_pick, zero pad
  input  wire logic [IN_DATA_W-1:0]  s_tdata,
  // req_type
  input  wire logic                  s_tuser,
  // result items
  output logic                       m_tvalid,
  input  wire logic                  m_tready,
  // pos_x, pos_y, pos_z, radius, alpha, life_left, expired
  output logic [OUT_DATA_W-1:0]      m_tdata,
  // register writes
  input  wire logic                  cfg_valid,
  output logic                       cfg_ready,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [WORD_W-1:0]     cfg_data
);

  pls_cmd_t  cmd;
  pls_stat_t st;

  assign cfg_ready = 1'b1;

  pls_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .cmd      (cmd),
    .st       (st)
  );

  pls_dp #(
    .FRAC_BITS (FRAC_BITS)
  ) u_dp (
    .clk      (clk),
    .rst      (rst),
    .cmd      (cmd),
    .st       (st),
    .in_data  (s_tdata),
    .cfg_we   (cfg_valid && cfg_ready),
    .cfg_idx  (cfg_index),
    .cfg_val  (cfg_data),
    .out_data (m_tdata)
  );

endmodule

`default_nettype wire
